// ----- src/ils_pkg.sv -----
package ils_pkg;

  // Coefficient and basis precision
  localparam int COEF_WIDTH      = 16;
  localparam int BASIS_FRAC_BITS = 14;

  // Port widths fixed by the item layout
  localparam int CoefPortW  = 16;
  localparam int PixelW     = 8;

  // Block geometry
  localparam int BlockN     = 8;
  localparam int IdxW       = $clog2(BlockN);
  localparam int BlockSize  = BlockN * BlockN;
  localparam int PosW       = 2 * IdxW;

  // Datapath widths
  localparam int BasisShift = 16 - BASIS_FRAC_BITS;
  localparam int BasisW     = BASIS_FRAC_BITS + 2;
  localparam int BbW        = 2 * BasisW;
  localparam int ProdW      = COEF_WIDTH + BbW;
  localparam int AccW       = ProdW + PosW;
  localparam int OutShift   = 2 * BASIS_FRAC_BITS + 2;

  // cos(m*pi/16) for m = 0..8 in Q1.16
  localparam int CosQ16 [9] = '{65536, 64277, 60547, 54491, 46341, 36410, 25080, 12785, 0};

  typedef enum logic [3:0] {
    SLoad  = 4'b0001,
    SIssue = 4'b0010,
    SWait  = 4'b0100,
    SEmit  = 4'b1000
  } state_e;

  // One multiply-accumulate term sent to the MAC
  typedef struct packed {
    logic            valid;
    logic            first;
    logic            last;
    logic [IdxW-1:0] u;
    logic [IdxW-1:0] x;
    logic [IdxW-1:0] v;
    logic [IdxW-1:0] y;
  } mac_issue_t;

  // Basis value C(k) * cos((2n+1) k pi / 16) at BASIS_FRAC_BITS fraction bits
  function automatic logic signed [BasisW-1:0] basis(input logic [IdxW-1:0] k,
                                                     input logic [IdxW-1:0] n);
    int   m;
    int   t;
    int   mag;
    logic neg;
    m = ((2 * int'(n) + 1) * int'(k)) & 31;
    if (k == '0) begin
      t = CosQ16[4];
    end else begin
      if (m > 16) m = 32 - m;
      if (m > 8) t = -CosQ16[16 - m];
      else       t = CosQ16[m];
    end
    neg = (t < 0);
    mag = neg ? -t : t;
    if (BasisShift > 0) mag = (mag + (1 << (BasisShift - 1))) >> BasisShift;
    return BasisW'(neg ? -mag : mag);
  endfunction

endpackage

// ----- src/ils_ram.sv -----
module ils_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- src/ils_mac.sv -----
module ils_mac import ils_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mac_issue_t                   issue_i,
  input  logic signed [COEF_WIDTH-1:0] coef_i,
  output logic signed [AccW-1:0]       acc_o,
  output logic                         done_o
);

  logic                   s1_valid_q, s1_first_q, s1_last_q;
  logic                   s2_valid_q, s2_first_q, s2_last_q;
  logic signed [BbW-1:0]  bb_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0] acc_q;
  logic                   done_q;

  // Advance control flags through the three stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_first_q <= 1'b0;
      s1_last_q  <= 1'b0;
      s2_valid_q <= 1'b0;
      s2_first_q <= 1'b0;
      s2_last_q  <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      s1_valid_q <= issue_i.valid;
      s1_first_q <= issue_i.first;
      s1_last_q  <= issue_i.last;
      s2_valid_q <= s1_valid_q;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
      done_q     <= s2_valid_q && s2_last_q;
    end
  end

  // Stage 1: product of row and column basis; coefficient read runs alongside
  always_ff @(posedge clk_i) begin
    bb_q <= basis(issue_i.u, issue_i.x) * basis(issue_i.v, issue_i.y);
  end

  // Stage 2: weight the coefficient
  always_ff @(posedge clk_i) begin
    prod_q <= coef_i * bb_q;
  end

  // Stage 3: accumulate, restart on the first term of a pixel
  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      if (s2_first_q) acc_q <= AccW'(prod_q);
      else            acc_q <= acc_q + AccW'(prod_q);
    end
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

  a_first_only_after_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> $past(issue_i.valid, 2))
    else $error("MAC stage 2 valid without an issued term");
  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(s2_last_q))
    else $error("MAC done without a last term");
  a_last_has_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_i.last |-> issue_i.valid)
    else $error("last term flag without valid");

endmodule

// ----- src/idct_8x8_level_shift_unit.sv -----
// Inverse 8x8 DCT with level shift, one shared multiply-accumulate unit.
// Input: one coefficient per cycle is taken while loading (64 items per block).
// After the 64th coefficient the block computes 64 pixels, 64 MAC terms each;
// each pixel goes through 64 issues, the 3 pipeline stages and 1 emit.
// Loading stops until the last pixel of a block is emitted, so throughput is set by
// the single MAC, and output stalls slow it further. Reset (rst_ni low, asynchronous)
// clears counters, state and output valid.
module idct_8x8_level_shift_unit import ils_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [CoefPortW-1:0] s_axis_tdata_i,  // [15:0] coefficient
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [PixelW-1:0]    m_axis_tdata_o,  // [7:0] pixel
  output logic                 m_axis_tlast_o   // last_pixel
);

  state_e state_q, state_d;
  logic [PosW-1:0] load_cnt_q, load_cnt_d;
  logic [PosW-1:0] pix_cnt_q, pix_cnt_d;
  logic [PosW-1:0] term_cnt_q, term_cnt_d;
  logic            out_valid_q, out_valid_d;
  logic [PixelW-1:0] pixel_q, pixel_d;
  logic            last_q, last_d;

  logic            in_acc;
  logic            out_free;
  mac_issue_t      issue;
  logic [COEF_WIDTH-1:0] rdata;
  logic signed [AccW-1:0] acc;
  logic            mac_done;
  logic signed [AccW-1:0] scaled;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == SLoad);

  // Coefficient store
  ils_ram #(.Width(COEF_WIDTH), .Depth(BlockSize)) u_store (
    .clk_i  (clk_i),
    .we_i   (in_acc),
    .waddr_i(load_cnt_q),
    .wdata_i(s_axis_tdata_i[COEF_WIDTH-1:0]),
    .raddr_i(term_cnt_q),
    .rdata_o(rdata)
  );

  // Term to issue: coefficient (u,v) for pixel (x,y)
  always_comb begin
    issue.valid = (state_q == SIssue);
    issue.first = (term_cnt_q == '0);
    issue.last  = (state_q == SIssue) && (term_cnt_q == PosW'(BlockSize - 1));
    issue.u     = term_cnt_q[PosW-1:IdxW];
    issue.v     = term_cnt_q[IdxW-1:0];
    issue.x     = pix_cnt_q[PosW-1:IdxW];
    issue.y     = pix_cnt_q[IdxW-1:0];
  end

  ils_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .issue_i(issue),
    .coef_i ($signed(rdata)),
    .acc_o  (acc),
    .done_o (mac_done)
  );

  // Floor by the scale, level shift and saturate
  assign scaled = acc >>> OutShift;
  always_comb begin
    if (scaled < AccW'(-128))     pixel_d = '0;
    else if (scaled > AccW'(127)) pixel_d = '1;
    else                          pixel_d = scaled[PixelW-1:0] ^ 8'h80;
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    load_cnt_d  = load_cnt_q;
    pix_cnt_d   = pix_cnt_q;
    term_cnt_d  = term_cnt_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    last_d      = last_q;
    unique case (state_q)
      SLoad: begin
        if (in_acc) begin
          load_cnt_d = load_cnt_q + 1'b1;
          if (load_cnt_q == PosW'(BlockSize - 1)) begin
            state_d    = SIssue;
            pix_cnt_d  = '0;
            term_cnt_d = '0;
          end
        end
      end
      SIssue: begin
        term_cnt_d = term_cnt_q + 1'b1;
        if (term_cnt_q == PosW'(BlockSize - 1)) state_d = SWait;
      end
      SWait: begin
        if (mac_done) state_d = SEmit;
      end
      SEmit: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          last_d      = (pix_cnt_q == PosW'(BlockSize - 1));
          pix_cnt_d   = pix_cnt_q + 1'b1;
          term_cnt_d  = '0;
          state_d     = (pix_cnt_q == PosW'(BlockSize - 1)) ? SLoad : SIssue;
        end
      end
      default: state_d = SLoad;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SLoad;
      load_cnt_q  <= '0;
      pix_cnt_q   <= '0;
      term_cnt_q  <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      load_cnt_q  <= load_cnt_d;
      pix_cnt_q   <= pix_cnt_d;
      term_cnt_q  <= term_cnt_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (state_q == SEmit && out_free) pixel_q <= pixel_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = pixel_q;
  assign m_axis_tlast_o  = last_q;

  a_no_issue_while_loading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SLoad) |-> !issue.valid)
    else $error("MAC term issued while loading");
  a_done_only_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> (state_q == SWait))
    else $error("MAC finished outside of wait state");
  a_load_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_cnt_q != '0) |-> (state_q == SLoad))
    else $error("partial block held while computing");
  a_last_ends_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEmit && out_free && pix_cnt_q == PosW'(BlockSize - 1))
      |=> (state_q == SLoad && m_axis_tlast_o))
    else $error("block end not flagged");

endmodule
